[src/lrupr_pkg.sv]
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and fixed widths for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

	// Port field widths
	localparam int PAGE_W  = 16;
	localparam int FIDX_W  = 2;
	localparam int TOTAL_W = 32;

	// Result of probing one frame against the reference key
	typedef struct packed {
		logic hit;    // valid and page matches
		logic empty;  // frame not valid
		logic lru;    // frame holds rank zero
	} lrupr_probe_t;

	// Table update issued by the sequencer at the end of a reference
	typedef struct packed {
		logic touch;  // make the chosen frame most recently used
		logic fill;   // write the key into the chosen frame, mark valid
	} lrupr_upd_t;

	// Outcome of one reference, handed to the result stage
	typedef struct packed {
		logic valid;
		logic hit;
		logic ev_valid;
	} lrupr_done_t;

endpackage

[src/lrupr_if.sv]
// ----------------------------------------------------------------------------
// lrupr_if
// Valid/ready channels: page reference in, replacement result out.
// ----------------------------------------------------------------------------
interface lrupr_ref_if;
	logic                        valid;
	logic                        ready;
	logic [lrupr_pkg::PAGE_W-1:0] page_number;

	modport source (output valid, output page_number, input ready);
	modport sink   (input valid, input page_number, output ready);
endinterface

interface lrupr_res_if;
	logic                         valid;
	logic                         ready;
	logic                         hit;
	logic [lrupr_pkg::FIDX_W-1:0]  frame_index;
	logic                         evicted_valid;
	logic [lrupr_pkg::PAGE_W-1:0]  evicted_page;
	logic [lrupr_pkg::TOTAL_W-1:0] hit_total;
	logic [lrupr_pkg::TOTAL_W-1:0] fault_total;

	modport source (output valid, output hit, output frame_index, output evicted_valid,
		output evicted_page, output hit_total, output fault_total, input ready);
	modport sink   (input valid, input hit, input frame_index, input evicted_valid,
		input evicted_page, input hit_total, input fault_total, output ready);
endinterface

[src/lrupr_table.sv]
// ----------------------------------------------------------------------------
// lrupr_table
// Frame storage (page, valid, recency rank) with a single-entry compare port.
// ----------------------------------------------------------------------------
module lrupr_table #(
	parameter int FRAMES = 4,
	parameter int SW     = 16,
	parameter int IW     = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [IW-1:0]           rd_idx,
	input  logic [SW-1:0]           key,
	input  lrupr_pkg::lrupr_upd_t   upd,
	input  logic [IW-1:0]           upd_idx,
	output lrupr_pkg::lrupr_probe_t probe,
	output logic [SW-1:0]           rd_page
);

	localparam logic [IW-1:0] RANK_TOP = IW'(FRAMES - 1);

	logic [SW-1:0] page_q  [FRAMES];
	logic [FRAMES-1:0] valid_q;
	logic [IW-1:0] rank_q  [FRAMES];
	logic [IW-1:0] old_rank;

	// shared compare unit, one frame per cycle
	assign rd_page     = page_q[rd_idx];
	assign probe.hit   = valid_q[rd_idx] && (page_q[rd_idx] == key);
	assign probe.empty = !valid_q[rd_idx];
	assign probe.lru   = (rank_q[rd_idx] == '0);

	assign old_rank = rank_q[upd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				rank_q[i] <= IW'(i);
			end
		end else begin
			if (upd.fill) begin
				valid_q[upd_idx] <= 1'b1;
			end
			if (upd.touch) begin
				for (int i = 0; i < FRAMES; i++) begin
					if (IW'(i) == upd_idx) begin
						rank_q[i] <= RANK_TOP;
					end else if (rank_q[i] > old_rank) begin
						rank_q[i] <= rank_q[i] - 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.fill) begin
			page_q[upd_idx] <= key;
		end
	end

endmodule

[src/lrupr_ctrl.sv]
// ----------------------------------------------------------------------------
// lrupr_ctrl
// Sequencer: walks the frames one per cycle, then picks and updates a frame.
// ----------------------------------------------------------------------------
module lrupr_ctrl #(
	parameter int FRAMES = 4,
	parameter int SW     = 16,
	parameter int IW     = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [SW-1:0]           start_page,
	output logic                    idle,
	input  lrupr_pkg::lrupr_probe_t probe,
	input  logic [SW-1:0]           rd_page,
	output logic [IW-1:0]           rd_idx,
	output logic [SW-1:0]           key,
	input  logic                    out_free,
	output lrupr_pkg::lrupr_upd_t   upd,
	output logic [IW-1:0]           frame,
	output lrupr_pkg::lrupr_done_t  done,
	output logic [SW-1:0]           ev_page
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	localparam logic [IW-1:0] LAST_IDX = IW'(FRAMES - 1);

	logic [1:0]    state_q;
	logic [IW-1:0] idx_q;
	logic [SW-1:0] key_q;
	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic          empty_q;
	logic [IW-1:0] empty_idx_q;
	logic [IW-1:0] lru_idx_q;
	logic [SW-1:0] lru_page_q;
	logic          ev_valid;
	logic          commit;

	assign idle   = (state_q == ST_IDLE);
	assign rd_idx = idx_q;
	assign key    = key_q;
	assign commit = (state_q == ST_UPD) && out_free;

	// hit wins, then lowest empty frame, then the LRU victim
	assign frame    = hit_q ? hit_idx_q : (empty_q ? empty_idx_q : lru_idx_q);
	assign ev_valid = !hit_q && !empty_q;
	assign ev_page  = ev_valid ? lru_page_q : '0;

	assign upd.touch     = commit;
	assign upd.fill      = commit && !hit_q;
	assign done.valid    = commit;
	assign done.hit      = hit_q;
	assign done.ev_valid = ev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX) state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (idle && start) begin
			key_q   <= start_page;
			idx_q   <= '0;
			hit_q   <= 1'b0;
			empty_q <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			if (probe.hit && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_q;
			end
			if (probe.empty && !empty_q) begin
				empty_q     <= 1'b1;
				empty_idx_q <= idx_q;
			end
			if (probe.lru) begin
				lru_idx_q  <= idx_q;
				lru_page_q <= rd_page;
			end
			if (idx_q != LAST_IDX) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

[src/lru_page_replacement_top.sv]
// ----------------------------------------------------------------------------
// lru_page_replacement_top
// LRU page replacement over FRAMES fully associative page frames.
// ----------------------------------------------------------------------------
// Each beat on ref_ch is one page reference; each beat on res_ch reports it.
// A reference is accepted only while the sequencer is idle, which latches
// the page. A single comparator then walks the frame table one frame per
// cycle, looking for a match, the lowest empty frame and the rank-zero
// frame, and the final step of each reference is to
// update the chosen frame and its recency ranks. The result sits in an output
// register, so a new reference is taken while the previous result waits; the
// update step holds only if that register is still full. Empty frames never
// match; on a fault the lowest empty frame is filled before any eviction.
// Page numbers are masked to PAGE_BITS (at most the 16-bit field). Hit and
// fault totals saturate at all ones. frame_index carries the low two bits of
// the frame number. Frame valid bits and ranks reset at once; no clearing pass.
// ----------------------------------------------------------------------------
module lru_page_replacement_top #(
	parameter int FRAMES    = 4,
	parameter int PAGE_BITS = 16
) (
	input logic                clk,
	input logic                arst_n,
	lrupr_ref_if.sink          ref_ch,
	lrupr_res_if.source        res_ch
);

	// stored page width: the port field caps it
	localparam int SW = (PAGE_BITS < lrupr_pkg::PAGE_W) ? PAGE_BITS : lrupr_pkg::PAGE_W;
	// frame index / rank width
	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	lrupr_pkg::lrupr_probe_t probe;
	lrupr_pkg::lrupr_upd_t   upd;
	lrupr_pkg::lrupr_done_t  done;

	logic          idle;
	logic          out_free;
	logic [IW-1:0] rd_idx;
	logic [IW-1:0] frame;
	logic [SW-1:0] key;
	logic [SW-1:0] rd_page;
	logic [SW-1:0] ev_page;

	// result register and running totals
	logic                             res_valid_q;
	logic                             res_hit_q;
	logic [lrupr_pkg::FIDX_W-1:0]     res_frame_q;
	logic                             res_ev_valid_q;
	logic [lrupr_pkg::PAGE_W-1:0]     res_ev_page_q;
	logic [lrupr_pkg::TOTAL_W-1:0]    hits_q;
	logic [lrupr_pkg::TOTAL_W-1:0]    faults_q;

	// accepted when idle; the register frees on the same edge it is read
	assign ref_ch.ready = idle;
	assign out_free     = !res_valid_q || res_ch.ready;

	lrupr_table #(
		.FRAMES (FRAMES),
		.SW     (SW),
		.IW     (IW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (rd_idx),
		.key     (key),
		.upd     (upd),
		.upd_idx (frame),
		.probe   (probe),
		.rd_page (rd_page)
	);

	lrupr_ctrl #(
		.FRAMES (FRAMES),
		.SW     (SW),
		.IW     (IW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (ref_ch.valid),
		.start_page (ref_ch.page_number[SW-1:0]),
		.idle       (idle),
		.probe      (probe),
		.rd_page    (rd_page),
		.rd_idx     (rd_idx),
		.key        (key),
		.out_free   (out_free),
		.upd        (upd),
		.frame      (frame),
		.done       (done),
		.ev_page    (ev_page)
	);

	// totals saturate at all ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			hits_q      <= '0;
			faults_q    <= '0;
		end else begin
			if (done.valid) begin
				res_valid_q <= 1'b1;
				if (done.hit && (hits_q != '1)) begin
					hits_q <= hits_q + 1'b1;
				end
				if (!done.hit && (faults_q != '1)) begin
					faults_q <= faults_q + 1'b1;
				end
			end else if (res_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done.valid) begin
			res_hit_q      <= done.hit;
			res_frame_q    <= lrupr_pkg::FIDX_W'(frame);
			res_ev_valid_q <= done.ev_valid;
			res_ev_page_q  <= lrupr_pkg::PAGE_W'(ev_page);
		end
	end

	assign res_ch.valid         = res_valid_q;
	assign res_ch.hit           = res_hit_q;
	assign res_ch.frame_index   = res_frame_q;
	assign res_ch.evicted_valid = res_ev_valid_q;
	assign res_ch.evicted_page  = res_ev_page_q;
	assign res_ch.hit_total     = hits_q;
	assign res_ch.fault_total   = faults_q;

`ifndef SYNTHESIS
	// an update only lands when the result register can take it
	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		done.valid |-> out_free)
		else $error("update committed over a pending result");

	// a committed update shows up as a result beat
	a_commit_shown: assert property (@(posedge clk) disable iff (!arst_n)
		done.valid |=> res_ch.valid)
		else $error("committed update not presented");

	// a reference cannot finish in the cycle after it is accepted
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(ref_ch.valid && ref_ch.ready) |=> !done.valid)
		else $error("update without a frame scan");

	// totals only move on a committed reference
	a_one_total: assert property (@(posedge clk) disable iff (!arst_n)
		(!done.valid) |=> ($stable(hits_q) && $stable(faults_q)))
		else $error("totals moved without a reference");
`endif

endmodule
